FILE: sv/breakpoint_line_table_writer_macros.svh
// Assertion macros for the breakpoint line table writer.
// Used by breakpoint_line_table_writer.sv; no other dependencies.
`ifndef BREAKPOINT_LINE_TABLE_WRITER_MACROS_SVH
`define BREAKPOINT_LINE_TABLE_WRITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BLT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/blt_pkg.sv
// Types and fixed constants for the breakpoint line table writer.
// No dependencies; imported by breakpoint_line_table_writer.sv.
package blt_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_SEGMENT = 2'd1,
    OP_FILL    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ORDER   = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;
  localparam logic [1:0] STATUS_CLIPPED = 2'd3;

  localparam logic [10:0] TABLE_LENGTH_RESET = 11'd1024;

  // Q32.16 ramp accumulator; entries are bits [47:16]
  localparam int ACC_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int DIV_STEPS = 48;

  typedef struct packed {
    op_t                operation;
    logic [15:0]        position;
    logic signed [31:0] level;
    logic [9:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_DIVIDE = 3'd2,
    ST_WRITE  = 3'd3,
    ST_FILL   = 3'd4,
    ST_READ   = 3'd5,
    ST_RESP   = 3'd6
  } state_t;

endpackage

FILE: sv/breakpoint_line_table_writer.sv
// Breakpoint line table writer: wavetable built from (position, level) breakpoints.
// Depends on blt_pkg and breakpoint_line_table_writer_macros.svh.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------
//   in      | input     | in_valid/in_stall | in_item_t (op, pos, level, idx)
//   out     | output    | out_valid/out_stall | out_item_t (value, status)
//   cfg     | input     | cfg_wr_en         | table_length (11 bits)
//
// One item at a time. Start: update, then response. Read: registered memory
// read, then response. Segment: serial divide (only when its length is 2 or
// more), then one table write per cycle until the segment or the used length
// ends, then response. Fill: writes up to the used length. The table memory
// has a single write port. After reset a clearing pass zeroes all TABLE_DEPTH
// entries, with in_stall high; configuration writes are taken during it.
// A result waits in the output register under out_stall; the next transfer
// is accepted meanwhile and its result is held until that register frees.
`include "breakpoint_line_table_writer_macros.svh"

module breakpoint_line_table_writer #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  blt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output blt_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [10:0]        cfg_wr_data
);
  import blt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

  // Table storage: one write port, one registered read port
  logic [31:0]   mem [TABLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  state_t state, state_next;

  // Architectural state
  logic [10:0]        table_length;
  logic [15:0]        last_position;
  logic signed [31:0] last_level;
  logic [CW-1:0]      cursor;
  logic               halted;
  logic [ACC_W-1:0]   acc;

  // Work registers
  logic [CW-1:0]      sweep;       // clear / fill address
  logic [15:0]        remain;
  logic [ACC_W-1:0]   incr;
  logic [31:0]        fill_level;
  logic               rd_ok;
  logic signed [31:0] res_value;
  logic [1:0]         res_status;

  // Serial divider: |diff| * 2^16 / (len - 1), one quotient bit a cycle
  logic [15:0]        div_rem;
  logic [ACC_W-1:0]   div_quo;
  logic [15:0]        div_den;
  logic               div_neg;
  logic [5:0]         div_cnt;
  logic [16:0]        div_shift;
  logic [15:0]        div_rem_step;
  logic [ACC_W-1:0]   div_quo_step;

  // Decode of the incoming item
  logic [15:0]        seg_remain;
  logic signed [32:0] seg_diff;
  logic [31:0]        seg_mag;
  logic               read_in_range;
  logic [16:0]        lim17;
  logic [CW-1:0]      lim;
  logic               write_go;
  logic               fill_go;
  logic               out_free;

  assign lim17 = (17'(table_length) > DEPTH17) ? DEPTH17 : 17'(table_length);
  assign lim   = CW'(lim17);

  assign seg_remain    = in_data.position - last_position;
  assign seg_diff      = 33'(in_data.level) - 33'(last_level);
  // magnitude never exceeds 2^32 - 1
  assign seg_mag       = 32'(seg_diff[32] ? -seg_diff : seg_diff);
  assign read_in_range = 17'(in_data.read_index) < DEPTH17;

  assign write_go = (remain != '0) && (cursor < lim);
  assign fill_go  = sweep < lim;
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != ST_IDLE);

  // remainder stays below the 16-bit divisor
  always_comb begin
    div_shift = {div_rem, div_quo[ACC_W-1]};
    if (div_shift >= {1'b0, div_den}) begin
      div_rem_step = 16'(div_shift - {1'b0, div_den});
      div_quo_step = {div_quo[ACC_W-2:0], 1'b1};
    end else begin
      div_rem_step = div_shift[15:0];
      div_quo_step = {div_quo[ACC_W-2:0], 1'b0};
    end
  end

  // Memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = sweep[AW-1:0];
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = AW'(in_data.read_index);
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (sweep == CW'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            OP_START: state_next = ST_RESP;
            OP_SEGMENT: begin
              if (halted || (in_data.position < last_position)) begin
                state_next = ST_RESP;
              end else if (seg_remain >= 16'd2) begin
                state_next = ST_DIVIDE;
              end else begin
                state_next = ST_WRITE;
              end
            end
            OP_FILL: state_next = ST_FILL;
            OP_READ: begin
              mem_re     = read_in_range;
              state_next = ST_READ;
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_DIVIDE: begin
        if (div_cnt == '0) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_waddr = cursor[AW-1:0];
        mem_wdata = acc[ACC_W-1:FRAC_W];
        if (write_go) begin
          mem_we = 1'b1;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_FILL: begin
        mem_wdata = fill_level;
        if (fill_go) begin
          mem_we = 1'b1;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_READ: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length  <= TABLE_LENGTH_RESET;
      last_position <= '0;
      last_level    <= '0;
      cursor        <= '0;
      halted        <= 1'b0;
      acc           <= '0;
      sweep         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_length <= cfg_wr_data;
      end
      // ST_RESP reloads the output register itself
      if (out_valid && !out_stall && (state != ST_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: sweep <= sweep + CW'(1);
        ST_IDLE: begin
          if (in_valid) begin
            res_value <= '0;
            case (in_data.operation)
              OP_START: begin
                res_status    <= STATUS_OK;
                last_position <= in_data.position;
                last_level    <= in_data.level;
                cursor        <= '0;
                halted        <= 1'b0;
              end
              OP_SEGMENT: begin
                if (halted) begin
                  res_status <= STATUS_IGNORED;
                end else if (in_data.position < last_position) begin
                  res_status <= STATUS_ORDER;
                  halted     <= 1'b1;
                end else begin
                  res_status    <= STATUS_OK;
                  remain        <= seg_remain;
                  acc           <= {last_level, 16'h0000};
                  incr          <= '0;
                  last_position <= in_data.position;
                  last_level    <= in_data.level;
                  div_quo       <= {seg_mag, 16'h0000};
                  div_rem       <= '0;
                  div_den       <= seg_remain - 16'd1;
                  div_neg       <= seg_diff[32];
                  div_cnt       <= 6'(DIV_STEPS - 1);
                end
              end
              OP_FILL: begin
                res_status <= STATUS_OK;
                sweep      <= '0;
                fill_level <= in_data.level;
              end
              OP_READ: begin
                rd_ok      <= read_in_range;
                res_status <= read_in_range ? STATUS_OK : STATUS_CLIPPED;
              end
              default: res_status <= STATUS_OK;
            endcase
          end
        end
        ST_DIVIDE: begin
          div_rem <= div_rem_step;
          div_quo <= div_quo_step;
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == '0) begin
            incr <= div_neg ? -div_quo_step : div_quo_step;
          end
        end
        ST_WRITE: begin
          if (write_go) begin
            acc    <= acc + incr;
            remain <= remain - 16'd1;
            cursor <= cursor + CW'(1);
          end else if (remain != '0) begin
            res_status <= STATUS_CLIPPED;
          end
        end
        ST_FILL: begin
          if (fill_go) begin
            sweep <= sweep + CW'(1);
          end
        end
        ST_READ: res_value <= rd_ok ? mem_rdata : '0;
        ST_RESP: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_data.value  <= res_value;
            out_data.status <= res_status;
          end
        end
        default: sweep <= sweep;
      endcase
    end
  end

  // Checks
  `BLT_ASSERT_SAME(a_waddr_in_range, clk, rst, mem_we, (17'(mem_waddr) < DEPTH17), "table write beyond depth")
  `BLT_ASSERT_SAME(a_cursor_bound, clk, rst, (state == ST_WRITE) && mem_we, (cursor < lim), "ramp write past used length")
  `BLT_ASSERT_NEXT(a_resp_waits, clk, rst, (state == ST_RESP) && out_valid && out_stall, (state == ST_RESP), "result dropped while output stalled")
  `BLT_ASSERT_NEXT(a_div_to_write, clk, rst, (state == ST_DIVIDE) && (div_cnt == '0), (state == ST_WRITE), "divider did not hand over to ramp")
  `BLT_ASSERT_SAME(a_halt_on_order, clk, rst, $rose(halted), (res_status == STATUS_ORDER), "halt without order error")

endmodule
